[src/scp_pkg.sv]
// Shared types, constants and fixed-point helpers for the polynomial calibration block.
package scp_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_COEFS     = 5;
    localparam int NUM_COEF_REGS = 5;
    localparam int COEF_LIM      = (MAX_COEFS < NUM_COEF_REGS) ? MAX_COEFS : NUM_COEF_REGS;
    localparam int HORNER_STEPS  = COEF_LIM - 1;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = (NUM_COEF_REGS > 1) ? $clog2(NUM_COEF_REGS) : 1;
    localparam int ADDR_W        = 5;
    localparam int APB_W         = 32;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] OFFSET_RST = '0;
    localparam logic signed [DATA_W-1:0] GAIN_RST   = DATA_W'(1 << FRAC_BITS);
    localparam logic [CNT_W-1:0]         COUNT_RST  = CNT_W'(2);

    typedef enum logic [2:0] {
        REG_RAW_OFFSET = 3'd0,
        REG_RAW_GAIN   = 3'd1,
        REG_COEF_COUNT = 3'd2,
        REG_COEF_ZERO  = 3'd3,
        REG_COEF_ONE   = 3'd4,
        REG_COEF_TWO   = 3'd5,
        REG_COEF_THREE = 3'd6,
        REG_COEF_FOUR  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } sat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] acc;
        logic                     ovf;
    } hstep_t;

    function automatic sat_t sat_wide(input logic signed [PROD_W-1:0] v);
        sat_t r;
        if (v > PROD_W'(SAT_MAX))
        begin
            r.val = SAT_MAX;
            r.ovf = 1'b1;
        end
        else if (v < PROD_W'(SAT_MIN))
        begin
            r.val = SAT_MIN;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t sat_sum(input logic signed [DATA_W:0] v);
        sat_t r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r.val = v[DATA_W] ? SAT_MIN : SAT_MAX;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // floor shift of a full product, then saturate
    function automatic sat_t qscale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC_BITS;
        return sat_wide(s);
    endfunction

endpackage

[src/scp_horner_step.sv]
// One Horner iteration: multiply stage, then scale, add and saturate stage.
module scp_horner_step
    import scp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     active,
    input  logic signed [DATA_W-1:0] coef,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hstep_t                   in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hstep_t                   out_data
);

    logic                     a_valid_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    hstep_t                   a_data_reg;
    logic                     a_ready;

    logic                     b_valid_reg;
    hstep_t                   b_data_reg;
    hstep_t                   b_data_next;
    logic                     b_ready;

    sat_t                     scaled;
    sat_t                     summed;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_data_reg <= in_data;
            a_prod_reg <= PROD_W'(in_data.x) * PROD_W'(in_data.acc);
        end
        if (b_ready && a_valid_reg)
            b_data_reg <= b_data_next;
    end

    always_comb
    begin
        scaled = qscale(a_prod_reg);
        summed = sat_sum((DATA_W+1)'(coef) + (DATA_W+1)'(scaled.val));
        b_data_next = a_data_reg;
        if (active)
        begin
            b_data_next.acc = summed.val;
            b_data_next.ovf = a_data_reg.ovf | scaled.ovf | summed.ovf;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

[src/sensor_polynomial_calibration.sv]
// Top level: APB register file, offset/gain stages and the Horner pipeline.
//
//   port group  | handshake               | payload
//   ------------+-------------------------+-------------------------------------
//   input word  | raw_valid / raw_ready   | raw_sample
//   output word | cal_valid / cal_ready   | calibrated_value, overflow_flag
//   config      | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// The front stages feed the Horner steps; one word per cycle is accepted while cal_ready does not stall the output.
// Every Horner step takes its two stages whatever coef_count is; unused steps pass through.
// Each stage holds its word while the next is full, so a stall back-pressures stage by stage.
// Reset clears all valid bits and loads the register defaults.
module sensor_polynomial_calibration
    import scp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready,
    input  logic                     raw_valid,
    output logic                     raw_ready,
    input  logic signed [DATA_W-1:0] raw_sample,
    output logic                     cal_valid,
    input  logic                     cal_ready,
    output logic signed [DATA_W-1:0] calibrated_value,
    output logic                     overflow_flag
);

    logic signed [DATA_W-1:0] offset_reg;
    logic signed [DATA_W-1:0] gain_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] coef_reg [NUM_COEF_REGS];

    reg_idx_t                 widx;
    logic                     wr_en;
    logic [CNT_W-1:0]         n_eff;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= OFFSET_RST;
            gain_reg    <= GAIN_RST;
            count_reg   <= COUNT_RST;
            coef_reg[0] <= '0;
            coef_reg[1] <= GAIN_RST;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_RAW_OFFSET: offset_reg  <= pwdata;
                REG_RAW_GAIN:   gain_reg    <= pwdata;
                REG_COEF_COUNT: count_reg   <= pwdata[CNT_W-1:0];
                REG_COEF_ZERO:  coef_reg[0] <= pwdata;
                REG_COEF_ONE:   coef_reg[1] <= pwdata;
                REG_COEF_TWO:   coef_reg[2] <= pwdata;
                REG_COEF_THREE: coef_reg[3] <= pwdata;
                REG_COEF_FOUR:  coef_reg[4] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_RAW_OFFSET: prdata = offset_reg;
            REG_RAW_GAIN:   prdata = gain_reg;
            REG_COEF_COUNT: prdata = APB_W'(count_reg);
            REG_COEF_ZERO:  prdata = coef_reg[0];
            REG_COEF_ONE:   prdata = coef_reg[1];
            REG_COEF_TWO:   prdata = coef_reg[2];
            REG_COEF_THREE: prdata = coef_reg[3];
            REG_COEF_FOUR:  prdata = coef_reg[4];
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        if (count_reg == '0)
            n_eff = CNT_W'(1);
        else if (count_reg > CNT_W'(COEF_LIM))
            n_eff = CNT_W'(COEF_LIM);
        else
            n_eff = count_reg;
    end

    // front stages: offset subtract, gain multiply, scale
    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_diff_reg;
    logic                     s1_ovf_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                     s2_ovf_reg;
    logic                     s3_valid_reg;
    hstep_t                   s3_data_reg;
    logic                     s1_ready;
    logic                     s2_ready;
    logic                     s3_ready;

    sat_t                     diff_sat;
    sat_t                     x_sat;

    logic                     step_valid [HORNER_STEPS+1];
    logic                     step_ready [HORNER_STEPS+1];
    hstep_t                   step_data  [HORNER_STEPS+1];

    assign s3_ready  = !s3_valid_reg || step_ready[0];
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign raw_ready = s1_ready;

    assign diff_sat = sat_sum((DATA_W+1)'(raw_sample) - (DATA_W+1)'(offset_reg));
    assign x_sat    = qscale(s2_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= raw_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && raw_valid)
        begin
            s1_diff_reg <= diff_sat.val;
            s1_ovf_reg  <= diff_sat.ovf;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= PROD_W'(s1_diff_reg) * PROD_W'(gain_reg);
            s2_ovf_reg  <= s1_ovf_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg.x   <= x_sat.val;
            s3_data_reg.acc <= coef_reg[IDX_W'(n_eff - CNT_W'(1))];
            s3_data_reg.ovf <= s2_ovf_reg | x_sat.ovf;
        end
    end

    assign step_valid[0] = s3_valid_reg;
    assign step_data[0]  = s3_data_reg;

    // step j applies coefficient k = HORNER_STEPS - j - 1 (zero based)
    genvar j;
    generate
        for (j = 0; j < HORNER_STEPS; j++)
        begin : g_step
            scp_horner_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (n_eff > CNT_W'(HORNER_STEPS - j)),
                .coef      (coef_reg[HORNER_STEPS - j - 1]),
                .in_valid  (step_valid[j]),
                .in_ready  (step_ready[j]),
                .in_data   (step_data[j]),
                .out_valid (step_valid[j+1]),
                .out_ready (step_ready[j+1]),
                .out_data  (step_data[j+1])
            );
        end
    endgenerate

    assign step_ready[HORNER_STEPS] = cal_ready;
    assign cal_valid        = step_valid[HORNER_STEPS];
    assign calibrated_value = step_data[HORNER_STEPS].acc;
    assign overflow_flag    = step_data[HORNER_STEPS].ovf;

endmodule
